// ===== rtl/qau_pkg.sv =====
// Shared types, constants and Hamilton product term tables for the quaternion
// arithmetic unit. No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package qau_pkg;

    localparam int CW = 16;
    localparam int FB = 14;
    localparam int NT = 4;
    localparam int PW = 2 * CW;
    localparam int AW = PW + 3;

    typedef logic [2:0] cmd_t;

    localparam cmd_t CMD_ADD   = 3'd0;
    localparam cmd_t CMD_SUB   = 3'd1;
    localparam cmd_t CMD_SCALE = 3'd2;
    localparam cmd_t CMD_MUL   = 3'd3;
    localparam cmd_t CMD_WRATE = 3'd4;
    localparam cmd_t CMD_LRATE = 3'd5;

    typedef struct packed {
        cmd_t                 command;
        logic signed [CW-1:0] a_real;
        logic signed [CW-1:0] a_i;
        logic signed [CW-1:0] a_j;
        logic signed [CW-1:0] a_k;
        logic signed [CW-1:0] b_real;
        logic signed [CW-1:0] b_i;
        logic signed [CW-1:0] b_j;
        logic signed [CW-1:0] b_k;
        logic signed [CW-1:0] scale_factor;
    } op_t;

    typedef struct packed {
        logic signed [CW-1:0] r_real;
        logic signed [CW-1:0] r_i;
        logic signed [CW-1:0] r_j;
        logic signed [CW-1:0] r_k;
        logic                 saturated;
    } res_t;

    typedef enum logic [1:0] {
        SHIFT_NONE,
        SHIFT_FRAC,
        SHIFT_HALF
    } shift_t;

    typedef struct packed {
        logic [NT-1:0][CW-1:0] x;
        logic [NT-1:0][CW-1:0] y;
        logic [NT-1:0]         neg;
        shift_t                shift;
    } lane_ops_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    typedef logic [1:0] idx_t;

    localparam idx_t HAM_X [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd3, 2'd1},
        '{2'd0, 2'd3, 2'd1, 2'd2}
    };

    localparam idx_t HAM_Y [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd3, 2'd0, 2'd2, 2'd1}
    };

    localparam logic [NT-1:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b1000, 4'b1000};

endpackage

// ===== rtl/qau_decode.sv =====
// Command decoder: maps a command and its operands onto four signed
// products per result component. Depends on qau_pkg.
`timescale 1ns / 1ps

module qau_decode
    import qau_pkg::*;
(
    input  op_t                  op,
    output lane_ops_t [NT-1:0]   ops
);

    logic [3:0][CW-1:0] a;
    logic [3:0][CW-1:0] b;
    logic [3:0][CW-1:0] w;
    logic [CW-1:0]      one;

    assign a   = {op.a_k, op.a_j, op.a_i, op.a_real};
    assign b   = {op.b_k, op.b_j, op.b_i, op.b_real};
    assign w   = {op.b_k, op.b_j, op.b_i, {CW{1'b0}}};
    assign one = CW'(1);

    always_comb
    begin
        for (int r = 0; r < NT; r++)
        begin
            ops[r].x     = '0;
            ops[r].y     = '0;
            ops[r].neg   = '0;
            ops[r].shift = SHIFT_NONE;
            case (op.command)
                CMD_ADD, CMD_SUB:
                begin
                    ops[r].x[0]   = a[r];
                    ops[r].y[0]   = one;
                    ops[r].x[1]   = b[r];
                    ops[r].y[1]   = one;
                    ops[r].neg[1] = (op.command == CMD_SUB);
                end
                CMD_SCALE:
                begin
                    ops[r].x[0]  = a[r];
                    ops[r].y[0]  = op.scale_factor;
                    ops[r].shift = SHIFT_FRAC;
                end
                CMD_MUL:
                begin
                    for (int t = 0; t < NT; t++)
                    begin
                        ops[r].x[t] = a[HAM_X[r][t]];
                        ops[r].y[t] = b[HAM_Y[r][t]];
                    end
                    ops[r].neg   = HAM_NEG[r];
                    ops[r].shift = SHIFT_FRAC;
                end
                CMD_WRATE:
                begin
                    for (int t = 0; t < NT; t++)
                    begin
                        ops[r].x[t] = w[HAM_X[r][t]];
                        ops[r].y[t] = a[HAM_Y[r][t]];
                    end
                    ops[r].neg   = HAM_NEG[r];
                    ops[r].shift = SHIFT_HALF;
                end
                CMD_LRATE:
                begin
                    for (int t = 0; t < NT; t++)
                    begin
                        ops[r].x[t] = a[HAM_X[r][t]];
                        ops[r].y[t] = w[HAM_Y[r][t]];
                    end
                    ops[r].neg   = HAM_NEG[r];
                    ops[r].shift = SHIFT_HALF;
                end
                default:
                begin
                    ops[r].shift = SHIFT_NONE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/qau_lane.sv =====
// One result component: a multiply stage, a sum-and-round stage and a
// shift-and-saturate stage. Depends on qau_pkg; the top level steers the enables.
`timescale 1ns / 1ps

module qau_lane
    import qau_pkg::*;
(
    input  logic                 clk,
    input  stage_en_t            en,
    input  lane_ops_t            ops,
    output logic signed [CW-1:0] r,
    output logic                 sat
);

    localparam logic signed [AW-1:0] R_MAX = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [AW-1:0] R_MIN = ~R_MAX;

    logic signed [PW-1:0] prod_reg  [NT];
    logic signed [PW-1:0] prod_next [NT];
    logic [NT-1:0]        neg_reg;
    shift_t               shift2_reg;
    logic signed [AW-1:0] sum_reg;
    logic signed [AW-1:0] sum_next;
    shift_t               shift3_reg;
    logic signed [AW-1:0] shifted;
    logic signed [CW-1:0] r_reg;
    logic signed [CW-1:0] r_next;
    logic                 sat_reg;
    logic                 sat_next;

    always_comb
    begin
        for (int t = 0; t < NT; t++)
        begin
            prod_next[t] = $signed(ops.x[t]) * $signed(ops.y[t]);
        end
    end

    always_comb
    begin
        case (shift2_reg)
            SHIFT_FRAC: sum_next = AW'(1) <<< (FB - 1);
            SHIFT_HALF: sum_next = AW'(1) <<< FB;
            default:    sum_next = '0;
        endcase
        for (int t = 0; t < NT; t++)
        begin
            if (neg_reg[t])
            begin
                sum_next = sum_next - AW'(prod_reg[t]);
            end
            else
            begin
                sum_next = sum_next + AW'(prod_reg[t]);
            end
        end
    end

    always_comb
    begin
        case (shift3_reg)
            SHIFT_FRAC: shifted = sum_reg >>> FB;
            SHIFT_HALF: shifted = sum_reg >>> (FB + 1);
            default:    shifted = sum_reg;
        endcase
        if (shifted > R_MAX)
        begin
            r_next   = R_MAX[CW-1:0];
            sat_next = 1'b1;
        end
        else if (shifted < R_MIN)
        begin
            r_next   = R_MIN[CW-1:0];
            sat_next = 1'b1;
        end
        else
        begin
            r_next   = shifted[CW-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            for (int t = 0; t < NT; t++)
            begin
                prod_reg[t] <= prod_next[t];
            end
            neg_reg    <= ops.neg;
            shift2_reg <= ops.shift;
        end
        if (en.s3)
        begin
            sum_reg    <= sum_next;
            shift3_reg <= shift2_reg;
        end
        if (en.s4)
        begin
            r_reg   <= r_next;
            sat_reg <= sat_next;
        end
    end

    assign r   = r_reg;
    assign sat = sat_reg;

endmodule

// ===== rtl/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit top level: input decode register, four component
// lanes and the pipeline valid control. Depends on qau_pkg, qau_decode, qau_lane.
`timescale 1ns / 1ps

// The unit takes one beat per cycle while op_ready is high and presents each result on res
// in order, one result beat per operand beat.
// The four register stages are operand decode, the sixteen 16x16 multipliers,
// the four-term sum with rounding, and the final shift and saturation; a stage
// holds its beat while the stage behind it is full and stalled, so back
// pressure on the result side reaches op_ready only once every stage is full.

module quaternion_arithmetic_unit
    import qau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic op_valid,
    output logic op_ready,
    input  op_t  op,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic                 v4_reg;
    logic                 en1;
    stage_en_t            en;
    lane_ops_t [NT-1:0]   ops_next;
    lane_ops_t [NT-1:0]   ops_reg;
    logic signed [CW-1:0] r_lane [NT];
    logic [NT-1:0]        sat_lane;

    assign en.s4 = !v4_reg || res_ready;
    assign en.s3 = !v3_reg || en.s4;
    assign en.s2 = !v2_reg || en.s3;
    assign en1   = !v1_reg || en.s2;

    assign op_ready  = en1;
    assign res_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= op_valid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (en.s4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    qau_decode u_decode (
        .op  (op),
        .ops (ops_next)
    );

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ops_reg <= ops_next;
        end
    end

    for (genvar g = 0; g < NT; g++)
    begin : g_lane
        qau_lane u_lane (
            .clk (clk),
            .en  (en),
            .ops (ops_reg[g]),
            .r   (r_lane[g]),
            .sat (sat_lane[g])
        );
    end

    assign res.r_real    = r_lane[0];
    assign res.r_i       = r_lane[1];
    assign res.r_j       = r_lane[2];
    assign res.r_k       = r_lane[3];
    assign res.saturated = |sat_lane;

endmodule

// ===== tb/quaternion_arithmetic_unit_tb.sv =====
// Self-checking testbench for quaternion_arithmetic_unit: a directed table and random beats,
// checked against an in-bench predictor under varied source idling and sink stalls.
// Depends on qau_pkg and the quaternion_arithmetic_unit RTL.
`timescale 1ns / 1ps

module quaternion_arithmetic_unit_tb;
    import qau_pkg::*;

    localparam cmd_t CMD_SPARE6 = 3'd6;
    localparam cmd_t CMD_SPARE7 = 3'd7;

    localparam int QMAX = 32767;
    localparam int QMIN = -32768;
    localparam int ONE = 1 << FB;
    localparam int HALF = 1 << (FB - 1);

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 16;
    localparam int RAND_PER_PHASE = 270;
    localparam int SEND_IDLE_PCT[4] = '{0, 73, 0, 37};
    localparam int SINK_STALL_PCT[4] = '{0, 0, 73, 37};

    typedef struct {
        op_t  o;
        bit   typed;
        res_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic op_valid;
    logic op_ready;
    op_t  op;
    logic res_valid;
    logic res_ready;
    res_t res;

    res_t     pending_res[$];
    dir_row_t dir_rows[$];
    int       mismatches = 0;
    int       send_idle = 0;
    int       sink_stall = 0;
    bit       hold_req = 1'b0;

    quaternion_arithmetic_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    function automatic longint round_shift(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic [CW-1:0] clip_comp(input longint v, inout bit clipped);
        longint hi;
        longint lo;
        longint c;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        c = v;
        if (v > hi)
        begin
            c = hi;
            clipped = 1'b1;
        end
        else if (v < lo)
        begin
            c = lo;
            clipped = 1'b1;
        end
        return c[CW-1:0];
    endfunction

    function automatic res_t quat_result(input op_t o);
        longint a[4];
        longint b[4];
        longint w[4];
        longint x[4];
        longint y[4];
        longint s[4];
        longint f;
        int     sh;
        bit     prod;
        bit     clipped;
        res_t   r;
        a[0] = $signed(o.a_real);
        a[1] = $signed(o.a_i);
        a[2] = $signed(o.a_j);
        a[3] = $signed(o.a_k);
        b[0] = $signed(o.b_real);
        b[1] = $signed(o.b_i);
        b[2] = $signed(o.b_j);
        b[3] = $signed(o.b_k);
        f = $signed(o.scale_factor);
        w[0] = 0;
        w[1] = b[1];
        w[2] = b[2];
        w[3] = b[3];
        x = a;
        y = b;
        sh = FB;
        prod = 1'b0;
        clipped = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            s[i] = 0;
        end
        case (o.command)
            CMD_ADD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    s[i] = a[i] + b[i];
                end
            end
            CMD_SUB:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    s[i] = a[i] - b[i];
                end
            end
            CMD_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    s[i] = round_shift(a[i] * f, FB);
                end
            end
            CMD_MUL:
            begin
                prod = 1'b1;
            end
            CMD_WRATE:
            begin
                x = w;
                y = a;
                sh = FB + 1;
                prod = 1'b1;
            end
            CMD_LRATE:
            begin
                x = a;
                y = w;
                sh = FB + 1;
                prod = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (prod)
        begin
            s[0] = x[0] * y[0] - x[1] * y[1] - x[2] * y[2] - x[3] * y[3];
            s[1] = x[0] * y[1] + x[1] * y[0] + x[2] * y[3] - x[3] * y[2];
            s[2] = x[0] * y[2] + x[2] * y[0] + x[3] * y[1] - x[1] * y[3];
            s[3] = x[0] * y[3] + x[3] * y[0] + x[1] * y[2] - x[2] * y[1];
            for (int i = 0; i < 4; i++)
            begin
                s[i] = round_shift(s[i], sh);
            end
        end
        r.r_real = clip_comp(s[0], clipped);
        r.r_i = clip_comp(s[1], clipped);
        r.r_j = clip_comp(s[2], clipped);
        r.r_k = clip_comp(s[3], clipped);
        r.saturated = clipped;
        return r;
    endfunction

    function automatic op_t mk_op(input cmd_t c, input int ar, input int ai, input int aj,
                                  input int ak, input int br, input int bi, input int bj,
                                  input int bk, input int f);
        op_t o;
        o.command = c;
        o.a_real = ar[CW-1:0];
        o.a_i = ai[CW-1:0];
        o.a_j = aj[CW-1:0];
        o.a_k = ak[CW-1:0];
        o.b_real = br[CW-1:0];
        o.b_i = bi[CW-1:0];
        o.b_j = bj[CW-1:0];
        o.b_k = bk[CW-1:0];
        o.scale_factor = f[CW-1:0];
        return o;
    endfunction

    function automatic res_t mk_res(input int r0, input int r1, input int r2, input int r3,
                                    input bit sat);
        res_t r;
        r.r_real = r0[CW-1:0];
        r.r_i = r1[CW-1:0];
        r.r_j = r2[CW-1:0];
        r.r_k = r3[CW-1:0];
        r.saturated = sat;
        return r;
    endfunction

    function automatic int rnd_comp();
        int v;
        case ($urandom_range(0, 7))
            0: v = QMAX;
            1: v = QMIN;
            2: v = int'($urandom_range(0, 2 * ONE)) - ONE;
            default: v = int'($urandom);
        endcase
        return v;
    endfunction

    function automatic op_t rnd_op();
        cmd_t c;
        if ($urandom_range(0, 15) == 0)
        begin
            c = cmd_t'($urandom_range(6, 7));
        end
        else
        begin
            c = cmd_t'($urandom_range(0, 5));
        end
        return mk_op(c, rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(),
                     rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
    endfunction

    task automatic send_beat(input op_t o, input bit typed, input res_t want);
        while ($urandom_range(0, 99) < send_idle)
        begin
            op_valid <= 1'b0;
            @(negedge clk);
        end
        op <= o;
        op_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!op_ready);
        pending_res.push_back(typed ? want : quat_result(o));
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic signed [CW-1:0] want,
                               input logic signed [CW-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            res_ready <= ($urandom_range(0, 99) >= sink_stall);
        end
    end

    always @(posedge clk)
    begin
        res_t w;
        if (res_valid && res_ready)
        begin
            if (pending_res.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat with none outstanding, actual %h", $time, res);
            end
            else
            begin
                w = pending_res.pop_front();
                check_field("r_real", w.r_real, res.r_real);
                check_field("r_i", w.r_i, res.r_i);
                check_field("r_j", w.r_j, res.r_j);
                check_field("r_k", w.r_k, res.r_k);
                check_field("saturated", w.saturated, res.saturated);
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((op_valid && op_ready) || (res_valid && res_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        op_valid = 1'b0;
        op = '0;

        // Directed rows, some with hand-computed results: saturation limits, unit quaternions and unused commands.
        dir_rows.push_back('{mk_op(CMD_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                             mk_res(0, 0, 0, 0, 1'b0)});
        dir_rows.push_back('{mk_op(CMD_ADD, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 0),
                             1'b1, mk_res(QMAX, QMAX, QMAX, QMAX, 1'b1)});
        dir_rows.push_back('{mk_op(CMD_ADD, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 0),
                             1'b1, mk_res(QMIN, QMIN, QMIN, QMIN, 1'b1)});
        dir_rows.push_back('{mk_op(CMD_SUB, QMIN, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMAX, 0),
                             1'b1, mk_res(QMIN, QMIN, QMIN, QMIN, 1'b1)});
        dir_rows.push_back('{mk_op(CMD_SUB, QMAX, QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, QMIN, 0),
                             1'b1, mk_res(QMAX, QMAX, QMAX, QMAX, 1'b1)});
        dir_rows.push_back('{mk_op(CMD_SUB, 1000, -2000, QMAX, QMIN, -1000, 2000, -1, 1, 0),
                             1'b0, '0});
        dir_rows.push_back('{mk_op(CMD_SCALE, ONE, -ONE, ONE, -ONE, 0, 0, 0, 0, ONE), 1'b1,
                             mk_res(ONE, -ONE, ONE, -ONE, 1'b0)});
        dir_rows.push_back('{mk_op(CMD_SCALE, QMIN, QMIN, QMIN, QMIN, 0, 0, 0, 0, QMIN), 1'b1,
                             mk_res(QMAX, QMAX, QMAX, QMAX, 1'b1)});
        dir_rows.push_back('{mk_op(CMD_SCALE, 1, -1, 3, -3, 0, 0, 0, 0, HALF), 1'b0, '0});
        dir_rows.push_back('{mk_op(CMD_SCALE, QMAX, QMAX, -5, 7, 0, 0, 0, 0, QMIN), 1'b0, '0});
        dir_rows.push_back('{mk_op(CMD_MUL, ONE, 0, 0, 0, ONE, 0, 0, 0, 0), 1'b1,
                             mk_res(ONE, 0, 0, 0, 1'b0)});
        dir_rows.push_back('{mk_op(CMD_MUL, 0, ONE, 0, 0, 0, ONE, 0, 0, 0), 1'b1,
                             mk_res(-ONE, 0, 0, 0, 1'b0)});
        dir_rows.push_back('{mk_op(CMD_MUL, 0, ONE, 0, 0, 0, 0, ONE, 0, 0), 1'b1,
                             mk_res(0, 0, 0, ONE, 1'b0)});
        dir_rows.push_back('{mk_op(CMD_MUL, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 0),
                             1'b0, '0});
        dir_rows.push_back('{mk_op(CMD_MUL, QMAX, QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, QMIN, 0),
                             1'b0, '0});
        dir_rows.push_back('{mk_op(CMD_MUL, 11585, -4000, 123, 9000, -7, 16000, -16000, 1, 0),
                             1'b0, '0});
        dir_rows.push_back('{mk_op(CMD_WRATE, ONE, 0, 0, 0, QMAX, ONE, 0, 0, 0), 1'b1,
                             mk_res(0, HALF, 0, 0, 1'b0)});
        dir_rows.push_back('{mk_op(CMD_LRATE, ONE, 0, 0, 0, QMIN, ONE, 0, 0, 0), 1'b1,
                             mk_res(0, HALF, 0, 0, 1'b0)});
        dir_rows.push_back('{mk_op(CMD_WRATE, QMIN, QMIN, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, 0),
                             1'b0, '0});
        dir_rows.push_back('{mk_op(CMD_LRATE, QMAX, QMAX, QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, 0),
                             1'b0, '0});
        dir_rows.push_back('{mk_op(CMD_SPARE6, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX,
                                   QMAX), 1'b1, mk_res(0, 0, 0, 0, 1'b0)});
        dir_rows.push_back('{mk_op(CMD_SPARE7, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN,
                                   QMIN), 1'b1, mk_res(0, 0, 0, 0, 1'b0)});

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[n])
        begin
            send_beat(dir_rows[n].o, dir_rows[n].typed, dir_rows[n].want);
        end

        // The first phase opens with a long sink hold while beats keep coming, to back up the
        // pipeline and stall the operand side.
        for (int p = 0; p < 4; p++)
        begin
            send_idle = SEND_IDLE_PCT[p];
            sink_stall = SINK_STALL_PCT[p];
            if (p == 0)
            begin
                hold_req = 1'b1;
            end
            repeat (RAND_PER_PHASE) send_beat(rnd_op(), 1'b0, '0);
        end
        op_valid <= 1'b0;

        while (pending_res.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_res.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/qau_pkg.sv
rtl/qau_decode.sv
rtl/qau_lane.sv
rtl/quaternion_arithmetic_unit.sv
tb/quaternion_arithmetic_unit_tb.sv
